[rtl/mid_pkg.sv]
package mid_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int LOCK_WIDTH   = SAMPLE_WIDTH - 1;
	localparam int GUARD        = 8;
	localparam int DCF          = 6;
	localparam int AMP_SHIFT    = SAMPLE_WIDTH - 1 + GUARD;

	// datapath widths
	localparam int CW   = 36;   // cordic x/y
	localparam int RW   = 26;   // de-rotated sample
	localparam int MGW  = 26;   // magnitude
	localparam int AW   = 33;   // leak operand
	localparam int MA_W = 36;
	localparam int MB_W = 33;
	localparam int P_W  = MA_W + MB_W;
	localparam int IDX_W = 5;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;

	localparam int INV_GAIN = 39797;
	localparam int LEAK_C   = 429497;
	localparam int LOCK_C   = 4294967;
	localparam int FM_SCALE = 4118;

	typedef enum logic [1:0] {
		MODE_PASS = 2'd0,
		MODE_AM   = 2'd1,
		MODE_SAM  = 2'd2,
		MODE_FM   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE  = 3'd0,
		REG_ALPHA = 3'd1,
		REG_BETA  = 3'd2,
		REG_FLO   = 3'd3,
		REG_FHI   = 3'd4
	} reg_idx_t;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	typedef struct packed {
		sample_t in_i;
		sample_t in_q;
	} in_t;

	typedef struct packed {
		sample_t                out_re;
		sample_t                out_im;
		logic [LOCK_WIDTH-1:0]  lock_level;
	} out_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_FM1, OP_FM2, OP_FM3, OP_FM4, OP_FM5,
		OP_RLOAD, OP_ITER_R, OP_RGX, OP_RGY, OP_RFIN,
		OP_VLOAD, OP_ITER_V, OP_VGX, OP_VMAG,
		OP_AM_D, OP_AM_M, OP_AM_U, OP_AM_S,
		OP_SAM_M, OP_SAM_D, OP_SAM_L, OP_SAM_LU, OP_SAM_C, OP_SAM_CU,
		OP_SAM_B, OP_SAM_F, OP_SAM_P, OP_FM_O
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] iter;
		logic             cap;
		logic             fin;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
	} stat_t;

	// arctangent of 2^-i in q0.32 turns
	function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] i);
		case (i)
			5'd0:    return 32'd536870912;
			5'd1:    return 32'd316933406;
			5'd2:    return 32'd167458907;
			5'd3:    return 32'd85004756;
			5'd4:    return 32'd42667331;
			5'd5:    return 32'd21354465;
			5'd6:    return 32'd10680862;
			5'd7:    return 32'd5340245;
			5'd8:    return 32'd2670163;
			5'd9:    return 32'd1335087;
			5'd10:   return 32'd667544;
			5'd11:   return 32'd333772;
			5'd12:   return 32'd166886;
			5'd13:   return 32'd83443;
			5'd14:   return 32'd41722;
			5'd15:   return 32'd20861;
			5'd16:   return 32'd10430;
			5'd17:   return 32'd5215;
			5'd18:   return 32'd2608;
			5'd19:   return 32'd1304;
			5'd20:   return 32'd652;
			5'd21:   return 32'd326;
			5'd22:   return 32'd163;
			5'd23:   return 32'd81;
			default: return 32'd0;
		endcase
	endfunction

	function automatic sample_t sat_sample(input logic signed [47:0] v);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		hi = (48'sd1 <<< (SAMPLE_WIDTH - 1)) - 48'sd1;
		lo = -hi - 48'sd1;
		if (v > hi) return hi[SAMPLE_WIDTH-1:0];
		if (v < lo) return lo[SAMPLE_WIDTH-1:0];
		return v[SAMPLE_WIDTH-1:0];
	endfunction

endpackage

[rtl/mid_dp.sv]
module mid_dp #(
	parameter int PHASE_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mid_pkg::cmd_t                   cmd,
	output mid_pkg::stat_t                  stat,
	input  mid_pkg::in_t                    in_data,
	output mid_pkg::out_t                   out_data,
	input  logic                            cfg_en,
	input  logic [mid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mid_pkg::CFG_W-1:0]       cfg_data
);
	import mid_pkg::*;

	localparam int PAD = 32 - PHASE_WIDTH;

	// configuration
	mode_t              mode_q;
	logic [31:0]        alpha_q, beta_q;
	logic signed [31:0] flo_q, fhi_q;

	// loop and filter state
	sample_t                  prev_i_q, prev_q_q;
	logic [PHASE_WIDTH-1:0]   nco_phase_q, nco_freq_q;
	logic signed [31:0]       am_dc_q, am_sm_q, sam_dc_q, lock_q;

	// working registers
	sample_t                  si_q, sq_q;
	logic signed [CW-1:0]     x_q, y_q;
	logic [31:0]              z_q, ang_q;
	logic                     zero_q;
	logic signed [RW-1:0]     rx_q, ry_q;
	logic signed [MGW-1:0]    mag_q;
	logic signed [AW-1:0]     a_q;
	logic signed [31:0]       diff_q;
	logic signed [P_W-1:0]    p_q;
	out_t                     out_q;

	logic signed [MA_W-1:0] ma;
	logic signed [MB_W-1:0] mb;
	logic                   mul_en;
	logic signed [P_W-1:0]  p16, p32, p33, ps23;

	logic signed [CW-1:0] sx, sy, x_n, y_n, ix, iy, vx, vy;
	logic [31:0]          at, z_n, ph_full, fr_full, rz0, ph_n;
	logic                 sub_dir, big;
	logic signed [MB_W-1:0] ang_s;
	logic signed [RW-1:0]   ry_abs;
	logic signed [AW-1:0]   am_a, lk_a, dc_a;
	logic signed [31:0]     diff_n, am_dcr, sam_dcr, am_v, lr;
	logic signed [33:0]     f, fl, fh, am_s, sam_t;
	logic signed [31:0]     am_sm_n;
	logic signed [33:0]     sam_v;
	sample_t                res;
	logic [LOCK_WIDTH-1:0]  lock_sat;

	assign stat.mode = mode_q;
	assign out_data  = out_q;

	assign p16  = (p_q + $signed(P_W'(1) << 15)) >>> 16;
	assign p32  = (p_q + $signed(P_W'(1) << 31)) >>> 32;
	assign p33  = (p_q + $signed(P_W'(1) << 32)) >>> 33;
	assign ps23 = p_q >>> AMP_SHIFT;

	// one cordic micro-rotation, shared by rotation and vectoring
	assign sx      = x_q >>> cmd.iter;
	assign sy      = y_q >>> cmd.iter;
	assign at      = atan_turn(cmd.iter);
	assign sub_dir = (cmd.op == OP_ITER_V) ? y_q[CW-1] : !z_q[31];
	assign x_n     = sub_dir ? x_q - sy : x_q + sy;
	assign y_n     = sub_dir ? y_q + sx : y_q - sx;
	assign z_n     = sub_dir ? z_q - at : z_q + at;

	assign ph_full = 32'(nco_phase_q) << PAD;
	assign fr_full = 32'(nco_freq_q) << PAD;
	assign rz0     = 32'd0 - ph_full;
	assign big     = ($signed(rz0) > 32'sh40000000) || ($signed(rz0) < -32'sh40000000);
	assign ix      = CW'(si_q) <<< GUARD;
	assign iy      = CW'(sq_q) <<< GUARD;

	always_comb begin
		case (mode_q)
			MODE_AM: begin
				vx = ix;
				vy = iy;
			end
			MODE_SAM: begin
				vx = CW'(rx_q);
				vy = CW'(ry_q);
			end
			default: begin
				vx = x_q;
				vy = y_q;
			end
		endcase
	end

	assign ang_s  = $signed({ang_q[31], ang_q});
	assign ry_abs = ry_q[RW-1] ? -ry_q : ry_q;
	assign am_a   = (AW'(mag_q) <<< DCF) - AW'(am_dc_q);
	assign lk_a   = (AW'(ry_abs) <<< DCF) - AW'(lock_q);
	assign dc_a   = (AW'(rx_q) <<< DCF) - AW'(sam_dc_q);

	always_comb begin
		if (ps23 > $signed(P_W'(32'h7FFFFFFF)))
			diff_n = 32'sh7FFFFFFF;
		else if (ps23 < -$signed(P_W'(33'h080000000)))
			diff_n = -32'sh7FFFFFFF - 32'sd1;
		else
			diff_n = ps23[31:0];
	end

	// frequency: integral path, clamp low then high
	always_comb begin
		f  = 34'($signed(fr_full)) + 34'(p32);
		fl = (f < 34'(flo_q)) ? 34'(flo_q) : f;
		fh = (fl > 34'(fhi_q)) ? 34'(fhi_q) : fl;
	end

	assign ph_n = ph_full + fr_full + p32[31:0];

	assign am_dcr  = (am_dc_q + 32'sd32) >>> DCF;
	assign am_s    = 34'(am_sm_q) + 34'(mag_q) - 34'(am_dcr);
	assign am_sm_n = 32'(am_s >>> 1);
	assign am_v    = (am_sm_q + 32'sd256) >>> (GUARD + 1);

	assign sam_dcr = (sam_dc_q + 32'sd32) >>> DCF;
	assign sam_t   = 34'(rx_q) - 34'(sam_dcr);
	assign sam_v   = (sam_t + 34'sd256) >>> (GUARD + 1);

	always_comb begin
		case (mode_q)
			MODE_AM:  res = sat_sample(48'(am_v));
			MODE_SAM: res = sat_sample(48'(sam_v));
			MODE_FM:  res = sat_sample(48'(p33));
			default:  res = si_q;
		endcase
	end

	assign lr = (lock_q + 32'sd8192) >>> (GUARD + DCF);
	always_comb begin
		if (lr > 32'sd32767)
			lock_sat = '1;
		else if (lr < 32'sd0)
			lock_sat = '0;
		else
			lock_sat = lr[LOCK_WIDTH-1:0];
	end

	// shared multiplier operand select
	always_comb begin
		ma     = '0;
		mb     = '0;
		mul_en = 1'b1;
		case (cmd.op)
			OP_FM1: begin
				ma = MA_W'(si_q);
				mb = MB_W'(prev_i_q);
			end
			OP_FM2: begin
				ma = MA_W'(sq_q);
				mb = MB_W'(prev_q_q);
			end
			OP_FM3: begin
				ma = MA_W'(sq_q);
				mb = MB_W'(prev_i_q);
			end
			OP_FM4: begin
				ma = MA_W'(si_q);
				mb = MB_W'(prev_q_q);
			end
			OP_RGX, OP_VGX: begin
				ma = x_q;
				mb = MB_W'(INV_GAIN);
			end
			OP_RGY: begin
				ma = y_q;
				mb = MB_W'(INV_GAIN);
			end
			OP_AM_M, OP_SAM_C: begin
				ma = MA_W'(a_q);
				mb = MB_W'(LEAK_C);
			end
			OP_SAM_L: begin
				ma = MA_W'(a_q);
				mb = MB_W'(LOCK_C);
			end
			OP_SAM_M: begin
				ma = MA_W'(mag_q);
				mb = ang_s;
			end
			OP_SAM_B: begin
				ma = MA_W'(diff_q);
				mb = $signed({1'b0, beta_q});
			end
			OP_SAM_F: begin
				ma = MA_W'(diff_q);
				mb = $signed({1'b0, alpha_q});
			end
			OP_FM_O: begin
				ma = MA_W'(FM_SCALE);
				mb = ang_s;
			end
			default: mul_en = 1'b0;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		if (mul_en)
			p_q <= ma * mb;
		if (cmd.cap) begin
			si_q <= in_data.in_i;
			sq_q <= in_data.in_q;
		end
		if (cmd.fin)
			out_q <= '{out_re: (mode_q == MODE_PASS) ? si_q : res,
			           out_im: (mode_q == MODE_PASS) ? sq_q : res,
			           lock_level: lock_sat};
		case (cmd.op)
			OP_FM2, OP_FM4: a_q <= AW'(p_q);
			OP_FM3: x_q <= CW'(a_q) + CW'(p_q);
			OP_FM5: y_q <= CW'(a_q) - CW'(p_q);
			OP_RLOAD: begin
				x_q <= big ? -ix : ix;
				y_q <= big ? -iy : iy;
				z_q <= big ? (rz0 ^ 32'h80000000) : rz0;
			end
			OP_ITER_R, OP_ITER_V: begin
				x_q <= x_n;
				y_q <= y_n;
				z_q <= z_n;
			end
			OP_RGY:  rx_q <= RW'(p16);
			OP_RFIN: ry_q <= RW'(p16);
			OP_VLOAD: begin
				zero_q <= (vx == '0) && (vy == '0);
				x_q    <= vx[CW-1] ? -vx : vx;
				y_q    <= vx[CW-1] ? -vy : vy;
				z_q    <= vx[CW-1] ? 32'h80000000 : 32'h0;
			end
			OP_VGX:    ang_q <= zero_q ? 32'h0 : z_q;
			OP_VMAG:   mag_q <= MGW'(p16);
			OP_AM_D:   a_q <= am_a;
			OP_SAM_D: begin
				diff_q <= diff_n;
				a_q    <= lk_a;
			end
			OP_SAM_LU: a_q <= dc_a;
			default: ;
		endcase
	end

	// model state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_AM;
			alpha_q     <= 32'd50596000;
			beta_q      <= 32'd149034;
			flo_q       <= -32'sd178956970;
			fhi_q       <= 32'sd178956970;
			prev_i_q    <= '0;
			prev_q_q    <= '0;
			nco_phase_q <= '0;
			nco_freq_q  <= '0;
			am_dc_q     <= '0;
			am_sm_q     <= '0;
			sam_dc_q    <= '0;
			lock_q      <= 32'sd1 <<< (AMP_SHIFT - 1 + DCF);
		end else begin
			case (cmd.op)
				OP_AM_U:   am_dc_q <= am_dc_q + 32'(p32);
				OP_AM_S:   am_sm_q <= am_sm_n;
				OP_SAM_LU: lock_q <= lock_q + 32'(p32);
				OP_SAM_CU: sam_dc_q <= sam_dc_q + 32'(p32);
				OP_SAM_F:  nco_freq_q <= fh[31 -: PHASE_WIDTH];
				OP_SAM_P:  nco_phase_q <= ph_n[31 -: PHASE_WIDTH];
				default: ;
			endcase
			if (cmd.fin) begin
				prev_i_q <= si_q;
				prev_q_q <= sq_q;
			end
			if (cfg_en) begin
				case (cfg_index)
					REG_MODE: begin
						mode_q      <= mode_t'(cfg_data[1:0]);
						nco_phase_q <= '0;
						nco_freq_q  <= '0;
						sam_dc_q    <= '0;
						lock_q      <= 32'sd1 <<< (AMP_SHIFT - 1 + DCF);
					end
					REG_ALPHA: alpha_q <= cfg_data;
					REG_BETA:  beta_q <= cfg_data;
					REG_FLO:   flo_q <= $signed(cfg_data);
					REG_FHI:   fhi_q <= $signed(cfg_data);
					default: ;
				endcase
			end
		end
	end

endmodule

[rtl/mid_ctrl.sv]
module mid_ctrl #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output mid_pkg::cmd_t    cmd,
	input  mid_pkg::stat_t   stat
);
	import mid_pkg::*;

	localparam int ITW = $clog2(CORDIC_STAGES);
	localparam logic [ITW-1:0] LAST = ITW'(CORDIC_STAGES - 1);

	typedef enum logic [29:0] {
		S_IDLE   = 30'b1 << 0,
		S_FM1    = 30'b1 << 1,
		S_FM2    = 30'b1 << 2,
		S_FM3    = 30'b1 << 3,
		S_FM4    = 30'b1 << 4,
		S_FM5    = 30'b1 << 5,
		S_RLOAD  = 30'b1 << 6,
		S_RITER  = 30'b1 << 7,
		S_RGX    = 30'b1 << 8,
		S_RGY    = 30'b1 << 9,
		S_RFIN   = 30'b1 << 10,
		S_VLOAD  = 30'b1 << 11,
		S_VITER  = 30'b1 << 12,
		S_VGX    = 30'b1 << 13,
		S_VMAG   = 30'b1 << 14,
		S_AM_D   = 30'b1 << 15,
		S_AM_M   = 30'b1 << 16,
		S_AM_U   = 30'b1 << 17,
		S_AM_S   = 30'b1 << 18,
		S_SAM_M  = 30'b1 << 19,
		S_SAM_D  = 30'b1 << 20,
		S_SAM_L  = 30'b1 << 21,
		S_SAM_LU = 30'b1 << 22,
		S_SAM_C  = 30'b1 << 23,
		S_SAM_CU = 30'b1 << 24,
		S_SAM_B  = 30'b1 << 25,
		S_SAM_F  = 30'b1 << 26,
		S_SAM_P  = 30'b1 << 27,
		S_FM_O   = 30'b1 << 28,
		S_DONE   = 30'b1 << 29
	} state_t;

	state_t         st_q, nxt;
	logic [ITW-1:0] iter_q;
	logic           out_valid_q;
	logic           iter_clr, iter_inc;
	op_t            op;
	logic           cap, fin;

	assign in_stall  = (st_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign cmd       = '{op: op, iter: IDX_W'(iter_q), cap: cap, fin: fin};

	always_comb begin
		nxt      = st_q;
		op       = OP_NONE;
		cap      = 1'b0;
		fin      = 1'b0;
		iter_clr = 1'b0;
		iter_inc = 1'b0;
		case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					cap = 1'b1;
					case (stat.mode)
						MODE_AM:  nxt = S_VLOAD;
						MODE_SAM: nxt = S_RLOAD;
						MODE_FM:  nxt = S_FM1;
						default:  nxt = S_DONE;
					endcase
				end
			end
			S_FM1: begin
				op  = OP_FM1;
				nxt = S_FM2;
			end
			S_FM2: begin
				op  = OP_FM2;
				nxt = S_FM3;
			end
			S_FM3: begin
				op  = OP_FM3;
				nxt = S_FM4;
			end
			S_FM4: begin
				op  = OP_FM4;
				nxt = S_FM5;
			end
			S_FM5: begin
				op  = OP_FM5;
				nxt = S_VLOAD;
			end
			S_RLOAD: begin
				op       = OP_RLOAD;
				iter_clr = 1'b1;
				nxt      = S_RITER;
			end
			S_RITER: begin
				op       = OP_ITER_R;
				iter_inc = 1'b1;
				if (iter_q == LAST)
					nxt = S_RGX;
			end
			S_RGX: begin
				op  = OP_RGX;
				nxt = S_RGY;
			end
			S_RGY: begin
				op  = OP_RGY;
				nxt = S_RFIN;
			end
			S_RFIN: begin
				op  = OP_RFIN;
				nxt = S_VLOAD;
			end
			S_VLOAD: begin
				op       = OP_VLOAD;
				iter_clr = 1'b1;
				nxt      = S_VITER;
			end
			S_VITER: begin
				op       = OP_ITER_V;
				iter_inc = 1'b1;
				if (iter_q == LAST)
					nxt = S_VGX;
			end
			S_VGX: begin
				op  = OP_VGX;
				nxt = S_VMAG;
			end
			S_VMAG: begin
				op = OP_VMAG;
				case (stat.mode)
					MODE_AM:  nxt = S_AM_D;
					MODE_SAM: nxt = S_SAM_M;
					default:  nxt = S_FM_O;
				endcase
			end
			S_AM_D: begin
				op  = OP_AM_D;
				nxt = S_AM_M;
			end
			S_AM_M: begin
				op  = OP_AM_M;
				nxt = S_AM_U;
			end
			S_AM_U: begin
				op  = OP_AM_U;
				nxt = S_AM_S;
			end
			S_AM_S: begin
				op  = OP_AM_S;
				nxt = S_DONE;
			end
			S_SAM_M: begin
				op  = OP_SAM_M;
				nxt = S_SAM_D;
			end
			S_SAM_D: begin
				op  = OP_SAM_D;
				nxt = S_SAM_L;
			end
			S_SAM_L: begin
				op  = OP_SAM_L;
				nxt = S_SAM_LU;
			end
			S_SAM_LU: begin
				op  = OP_SAM_LU;
				nxt = S_SAM_C;
			end
			S_SAM_C: begin
				op  = OP_SAM_C;
				nxt = S_SAM_CU;
			end
			S_SAM_CU: begin
				op  = OP_SAM_CU;
				nxt = S_SAM_B;
			end
			S_SAM_B: begin
				op  = OP_SAM_B;
				nxt = S_SAM_F;
			end
			S_SAM_F: begin
				op  = OP_SAM_F;
				nxt = S_SAM_P;
			end
			S_SAM_P: begin
				op  = OP_SAM_P;
				nxt = S_DONE;
			end
			S_FM_O: begin
				op  = OP_FM_O;
				nxt = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					fin = 1'b1;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= nxt;
			if (iter_clr)
				iter_q <= '0;
			else if (iter_inc)
				iter_q <= iter_q + ITW'(1);
			if (fin)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/multimode_iq_demodulator.sv]
// passthrough skips the cordic; am and narrow fm run one cordic vectoring pass,
// synchronous am a rotation pass and then a vectoring pass
// one request at a time; the next is taken the cycle after its result is registered,
// so requests never overlap on the single shared cordic and multiplier
// arst_n clears the loop, filter and previous-sample state (the lock filter is preset)
// and loads register defaults (am mode); result register starts empty
module multimode_iq_demodulator #(
	parameter int PHASE_WIDTH   = 32,   // kept bits of nco phase and frequency
	parameter int CORDIC_STAGES = 16    // cordic iterations, 8 to 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample request channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  mid_pkg::in_t                    in_data,
	// demodulated result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output mid_pkg::out_t                   out_data,
	// register writes
	input  logic                            cfg_en,
	input  logic [mid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mid_pkg::CFG_W-1:0]       cfg_data
);
	import mid_pkg::*;

	// controller sequences datapath ops one per cycle unless idle or stalled
	cmd_t  cmd;
	stat_t stat;

	// fsm: mode dispatch, cordic iteration count, result handoff
	mid_ctrl #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// datapath: shared cordic, shared multiplier, pll, dc and lock filters,
	// configuration registers and the output register
	mid_dp #(
		.PHASE_WIDTH (PHASE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

[rtl/mid_chk.sv]
module mid_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input mid_pkg::out_t  out_data
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a taken request makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken without going busy");

	// a new result only follows a busy cycle
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a request in flight");

endmodule

bind multimode_iq_demodulator mid_chk u_chk (.*);
